// ===== rtl/wtnf_pkg.sv =====
// package: shared types and constants for the wire tangent normal frame
package wtnf_pkg;

    localparam int ONE_Q14 = 16384;
    localparam int MAG_W   = 15;
    localparam int S_W     = 64;
    localparam int R_W     = 93;
    localparam int ACC_W   = 98;

    typedef struct packed {
        logic [S_W-1:0]   s;
        logic [R_W-1:0]   rx;
        logic [R_W-1:0]   ry;
        logic [ACC_W-1:0] px;
        logic [ACC_W-1:0] py;
        logic [ACC_W-1:0] qx;
        logic [ACC_W-1:0] qy;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic             zero;
        logic             wx_neg;
        logic             wy_neg;
        logic             turn_neg;
    } work_t;

endpackage

// ===== rtl/wtnf_in_if.sv =====
// interface: input transaction channel
interface wtnf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] current_x;
    logic [31:0] wire_x;
    logic [31:0] wire_y;

    modport source (output valid, current_x, wire_x, wire_y, input ready);
    modport sink (input valid, current_x, wire_x, wire_y, output ready);
endinterface

// ===== rtl/wtnf_out_if.sv =====
// interface: result transaction channel
interface wtnf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] unit_x;
    logic [15:0] unit_y;
    logic [14:0] tangent_x;
    logic [15:0] tangent_y;
    logic [15:0] normal_x;
    logic [15:0] normal_y;

    modport source (output valid, unit_x, unit_y, tangent_x, tangent_y, normal_x, normal_y,
                    input ready);
    modport sink (input valid, unit_x, unit_y, tangent_x, tangent_y, normal_x, normal_y,
                  output ready);
endinterface

// ===== rtl/wtnf_front.sv =====
// front stage: magnitudes, squared length, compare bounds and sign flags
module wtnf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  valid_in,
    input  logic [31:0]           current_x,
    input  logic [31:0]           wire_x,
    input  logic [31:0]           wire_y,
    output logic                  valid_out,
    output wtnf_pkg::work_t       item_out
);
    logic [31:0]          ax;
    logic [31:0]          ay;
    logic [63:0]          ax2;
    logic [63:0]          ay2;
    logic                 valid_reg;
    wtnf_pkg::work_t      item_reg;
    wtnf_pkg::work_t      item_next;

    assign ax  = wire_x[31] ? (~wire_x + 32'd1) : wire_x;
    assign ay  = wire_y[31] ? (~wire_y + 32'd1) : wire_y;
    assign ax2 = 64'(ax) * 64'(ax);
    assign ay2 = 64'(ay) * 64'(ay);

    always_comb
    begin
        item_next.s        = ax2 + ay2;
        item_next.rx       = {ax2[62:0], 30'd0};
        item_next.ry       = {ay2[62:0], 30'd0};
        item_next.px       = {34'd0, item_next.s};
        item_next.py       = {34'd0, item_next.s};
        item_next.qx       = ~{34'd0, item_next.s} + 98'd1;
        item_next.qy       = ~{34'd0, item_next.s} + 98'd1;
        item_next.mx       = '0;
        item_next.my       = '0;
        item_next.zero     = (wire_x == 32'd0) && (wire_y == 32'd0);
        item_next.wx_neg   = wire_x[31];
        item_next.wy_neg   = wire_y[31];
        item_next.turn_neg = (current_x != 32'd0) && (wire_y != 32'd0)
                             && (current_x[31] ^ wire_y[31] ^ wire_x[31]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;
endmodule

// ===== rtl/wtnf_cell.sv =====
// cell: decides one bit of both normalized magnitudes
module wtnf_cell #(
    parameter int K = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             valid_in,
    input  wtnf_pkg::work_t  item_in,
    output logic             valid_out,
    output wtnf_pkg::work_t  item_out
);
    localparam int W = wtnf_pkg::ACC_W;

    logic [W-1:0]     s_wide;
    logic [W-1:0]     cand_x;
    logic [W-1:0]     cand_y;
    logic             ok_x;
    logic             ok_y;
    logic             valid_reg;
    wtnf_pkg::work_t  item_reg;
    wtnf_pkg::work_t  item_next;

    assign s_wide = {{(W - wtnf_pkg::S_W){1'b0}}, item_in.s};
    assign cand_x = item_in.px + (item_in.qx << (K + 2)) + (s_wide << (2 * K + 2));
    assign cand_y = item_in.py + (item_in.qy << (K + 2)) + (s_wide << (2 * K + 2));
    assign ok_x   = cand_x <= {{(W - wtnf_pkg::R_W){1'b0}}, item_in.rx};
    assign ok_y   = cand_y <= {{(W - wtnf_pkg::R_W){1'b0}}, item_in.ry};

    always_comb
    begin
        item_next = item_in;
        if (ok_x)
        begin
            item_next.px    = cand_x;
            item_next.qx    = item_in.qx + (s_wide << (K + 1));
            item_next.mx[K] = 1'b1;
        end
        if (ok_y)
        begin
            item_next.py    = cand_y;
            item_next.qy    = item_in.qy + (s_wide << (K + 1));
            item_next.my[K] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= item_next;
        end
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;
endmodule

// ===== rtl/wire_tangent_normal_frame.sv =====
// top level: wire tangent and normal frame pipeline
//
// Fully pipelined: one transaction is accepted per cycle unless the output
// stalls. Its result passes through one front stage, a chain of 15 cells each
// resolving one bit of both normalized magnitudes, and the output register.
// The whole chain holds while the result at the output is not taken.
module wire_tangent_normal_frame (
    input logic        clk,
    input logic        rst_n,
    wtnf_in_if.sink    item_in,
    wtnf_out_if.source result_out
);
    localparam int NB = wtnf_pkg::MAG_W;

    logic                 adv;
    logic                 valid_c [NB+1];
    wtnf_pkg::work_t      item_c  [NB+1];
    wtnf_pkg::work_t      fin;
    logic [15:0]          ux;
    logic [15:0]          uy;
    logic [15:0]          ty;
    logic [14:0]          tx;
    logic                 out_valid_reg;
    logic [15:0]          ux_reg;
    logic [15:0]          uy_reg;
    logic [14:0]          tx_reg;
    logic [15:0]          ty_reg;
    logic [15:0]          nx_reg;
    logic [15:0]          ny_reg;
    logic [15:0]          nx_next;
    logic [15:0]          ny_next;

    assign adv          = !out_valid_reg || result_out.ready;
    assign item_in.ready = adv;

    wtnf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (item_in.valid),
        .current_x (item_in.current_x),
        .wire_x    (item_in.wire_x),
        .wire_y    (item_in.wire_y),
        .valid_out (valid_c[0]),
        .item_out  (item_c[0])
    );

    for (genvar i = 0; i < NB; i++)
    begin : g_cell
        wtnf_cell #(.K(NB - 1 - i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (valid_c[i]),
            .item_in   (item_c[i]),
            .valid_out (valid_c[i+1]),
            .item_out  (item_c[i+1])
        );
    end

    assign fin = item_c[NB];

    always_comb
    begin
        if (fin.zero)
        begin
            ux = 16'(wtnf_pkg::ONE_Q14);
            uy = 16'd0;
            tx = 15'(wtnf_pkg::ONE_Q14);
        end
        else
        begin
            ux = fin.wx_neg ? (16'd0 - {1'b0, fin.mx}) : {1'b0, fin.mx};
            uy = fin.wy_neg ? (16'd0 - {1'b0, fin.my}) : {1'b0, fin.my};
            tx = fin.mx;
        end
        ty = fin.wx_neg ? (16'd0 - uy) : uy;
        if (fin.turn_neg)
        begin
            nx_next = 16'd0 - ty;
            ny_next = {1'b0, tx};
        end
        else
        begin
            nx_next = ty;
            ny_next = 16'd0 - {1'b0, tx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_c[NB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ux_reg <= ux;
            uy_reg <= uy;
            tx_reg <= tx;
            ty_reg <= ty;
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
    end

    assign result_out.valid     = out_valid_reg;
    assign result_out.unit_x    = ux_reg;
    assign result_out.unit_y    = uy_reg;
    assign result_out.tangent_x = tx_reg;
    assign result_out.tangent_y = ty_reg;
    assign result_out.normal_x  = nx_reg;
    assign result_out.normal_y  = ny_reg;
endmodule
